[rtl/core/varint_tag_value_message_decoder_assert.svh]
// Assertion shorthands for the message decoder. Each use expects clk and arst_n in scope.
`ifndef VARINT_TAG_VALUE_MESSAGE_DECODER_ASSERT_SVH
`define VARINT_TAG_VALUE_MESSAGE_DECODER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define VTVD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define VTVD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/vtvd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vtvd_pkg;

	localparam int unsigned VarintMaxBytes = 10;
	localparam int unsigned CntW           = 4;
	localparam int unsigned AccW           = 64;

	// Field numbers carried in a tag.
	localparam logic [2:0] FieldMouseX = 3'd1;
	localparam logic [2:0] FieldMouseY = 3'd2;
	localparam logic [2:0] FieldMouseZ = 3'd3;
	localparam logic [2:0] FieldLeft   = 3'd4;
	localparam logic [2:0] FieldRight  = 3'd5;
	localparam logic [2:0] FieldKeys   = 3'd6;
	localparam logic [2:0] FieldExtra  = 3'd7;

	typedef struct packed {
		logic signed [15:0] mouse_x;
		logic signed [15:0] mouse_y;
		logic signed [15:0] mouse_z;
		logic               left_button;
		logic               right_button;
		logic [15:0]        key_mask;
		logic [15:0]        extra_bits;
	} vtvd_rec_t;

	// View of the varint after merging the current byte.
	typedef struct packed {
		logic            done;
		logic            cont;
		logic            overflow;
		logic [AccW-1:0] value;
	} vtvd_vint_t;

	// Control from the message tracker to the varint assembler.
	typedef struct packed {
		logic take;
		logic clear;
	} vtvd_ctl_t;

	typedef struct packed {
		logic      decode_ok;
		vtvd_rec_t rec;
	} vtvd_result_t;

endpackage

`default_nettype wire

[rtl/core/vtvd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface vtvd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       last_byte;

	modport source (output valid, output byte_in, output last_byte, input ready);
	modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface vtvd_rec_if;
	logic               valid;
	logic               ready;
	logic               decode_ok;
	logic signed [15:0] mouse_x;
	logic signed [15:0] mouse_y;
	logic signed [15:0] mouse_z;
	logic               left_button;
	logic               right_button;
	logic [15:0]        key_mask;
	logic [15:0]        extra_bits;

	modport source (output valid, output decode_ok, output mouse_x, output mouse_y,
		output mouse_z, output left_button, output right_button, output key_mask,
		output extra_bits, input ready);
	modport sink (input valid, input decode_ok, input mouse_x, input mouse_y,
		input mouse_z, input left_button, input right_button, input key_mask,
		input extra_bits, output ready);
endinterface

`default_nettype wire

[rtl/core/vtvd_varint.sv]
`timescale 1ns / 1ps
`default_nettype none

module vtvd_varint import vtvd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] byte_in,
	input  wire vtvd_ctl_t  ctl,
	output vtvd_vint_t      vint
);

	logic [AccW-1:0] acc_q;
	logic [CntW-1:0] cnt_q;
	logic [6:0]      shamt;
	logic [AccW-1:0] shifted;

	// 7 * count as 8 * count - count
	assign shamt   = {cnt_q, 3'b000} - {3'b000, cnt_q};
	assign shifted = {{(AccW-7){1'b0}}, byte_in[6:0]} << shamt;

	always_comb begin
		vint.value    = acc_q | shifted;
		vint.cont     = byte_in[7];
		vint.done     = !byte_in[7];
		vint.overflow = byte_in[7] && (cnt_q == CntW'(VarintMaxBytes - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (ctl.take) begin
			if (byte_in[7]) begin
				acc_q <= vint.value;
				cnt_q <= cnt_q + CntW'(1);
			end else begin
				acc_q <= '0;
				cnt_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/vtvd_msg.sv]
`timescale 1ns / 1ps
`default_nettype none

module vtvd_msg import vtvd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic       last,
	input  wire vtvd_vint_t vint,
	output vtvd_ctl_t       ctl,
	output vtvd_result_t    result
);

	logic       phase_q;
	logic [2:0] field_q;
	vtvd_rec_t  work_q;
	vtvd_rec_t  held_q;
	logic       any_q;
	logic       err_q;

	logic       phase_n;
	logic [2:0] field_n;
	vtvd_rec_t  work_n;
	logic       any_n;
	logic       err_n;
	logic       take;
	logic       tag_bad;
	logic       nonzero;
	logic [15:0] sat;
	logic       fail;
	logic       ok;

	// Saturate a signed 32-bit word to 16 bits.
	function automatic logic [15:0] sat16(input logic [31:0] u);
		logic [15:0] r;
		if (!u[31]) begin
			r = (u[30:15] != 16'h0000) ? 16'h7FFF : u[15:0];
		end else begin
			r = (u[30:15] != 16'hFFFF) ? 16'h8000 : u[15:0];
		end
		return r;
	endfunction

	assign take    = step && !err_q;
	assign tag_bad = (vint.value[2:0] != 3'd0) || (vint.value[34:6] != '0)
		|| (vint.value[5:3] == 3'd0);
	assign nonzero = |vint.value;
	assign sat     = sat16(vint.value[31:0]);

	always_comb begin
		phase_n = phase_q;
		field_n = field_q;
		work_n  = work_q;
		any_n   = any_q;
		err_n   = err_q;
		if (take) begin
			if (vint.overflow) begin
				err_n = 1'b1;
			end
			if (vint.done) begin
				if (!phase_q) begin
					if (tag_bad) begin
						err_n = 1'b1;
					end else begin
						field_n = vint.value[5:3];
						phase_n = 1'b1;
					end
				end else begin
					phase_n = 1'b0;
					any_n   = 1'b1;
					case (field_q)
						FieldMouseX: work_n.mouse_x      = sat;
						FieldMouseY: work_n.mouse_y      = sat;
						FieldMouseZ: work_n.mouse_z      = sat;
						FieldLeft:   work_n.left_button  = nonzero;
						FieldRight:  work_n.right_button = nonzero;
						FieldKeys: begin
							work_n.key_mask   = vint.value[15:0];
							work_n.extra_bits = vint.value[31:16];
						end
						FieldExtra:  work_n.extra_bits[0] = nonzero;
						default: begin
							err_n = 1'b1;
							any_n = any_q;
						end
					endcase
				end
			end
		end
	end

	// Truncated varint or a tag without its value fails the message.
	assign fail = err_n || (take && vint.cont) || phase_n;
	assign ok   = !fail && any_n;

	always_comb begin
		ctl.take         = take;
		ctl.clear        = step && last;
		result.decode_ok = ok;
		result.rec       = ok ? work_n : held_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			field_q <= '0;
			work_q  <= '0;
			held_q  <= '0;
			any_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				phase_q <= 1'b0;
				field_q <= '0;
				work_q  <= '0;
				any_q   <= 1'b0;
				err_q   <= 1'b0;
				held_q  <= result.rec;
			end else begin
				phase_q <= phase_n;
				field_q <= field_n;
				work_q  <= work_n;
				any_q   <= any_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/varint_tag_value_message_decoder.sv]
// Streaming decoder for a small tag/value message of base-128 varints.
// byte_ch: one message byte per transfer, last_byte set on the final byte.
// rec_ch: one transfer per message, issued for its final byte only. It carries
//   decode_ok and the held record (mouse x/y/z, buttons, key mask, extra bits).
//   A failed message leaves the held record as it was and reports decode_ok 0.
// Throughput: one byte per cycle while no final byte waits in s1, through the
//   s1 input register and a single pass of varint merge plus field update into
//   the result register.
// Stall: while rec_ch is stalled, non-final bytes keep flowing; a final byte
//   waits in s1 and byte_ch drops ready until the result register frees up.
// Reset: arst_n clears the varint state, the working and held records, and
//   both valid flags; the first message after reset starts on a clean state.
`timescale 1ns / 1ps
`default_nettype none
`include "varint_tag_value_message_decoder_assert.svh"

module varint_tag_value_message_decoder import vtvd_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	vtvd_byte_if.sink   byte_ch,
	vtvd_rec_if.source  rec_ch
);

	// Input stage
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;

	// Result register
	logic         res_valid_q;
	vtvd_result_t res_q;

	logic         out_free;
	logic         adv_s1;
	logic         res_wr;
	vtvd_vint_t   vint;
	vtvd_ctl_t    ctl;
	vtvd_result_t result;

	// A final byte needs room in the result register; other bytes always advance.
	assign out_free      = !res_valid_q || rec_ch.ready;
	assign adv_s1        = valid_s1 && (!last_s1 || out_free);
	assign res_wr        = adv_s1 && last_s1;
	assign byte_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	// Capture payload on each accepted transfer.
	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.byte_in;
			last_s1 <= byte_ch.last_byte;
		end
	end

	vtvd_varint u_varint (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_s1),
		.ctl     (ctl),
		.vint    (vint)
	);

	vtvd_msg u_msg (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.last   (last_s1),
		.vint   (vint),
		.ctl    (ctl),
		.result (result)
	);

	// Hold the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_wr) begin
			res_valid_q <= 1'b1;
		end else if (rec_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr) begin
			res_q <= result;
		end
	end

	assign rec_ch.valid        = res_valid_q;
	assign rec_ch.decode_ok    = res_q.decode_ok;
	assign rec_ch.mouse_x      = res_q.rec.mouse_x;
	assign rec_ch.mouse_y      = res_q.rec.mouse_y;
	assign rec_ch.mouse_z      = res_q.rec.mouse_z;
	assign rec_ch.left_button  = res_q.rec.left_button;
	assign rec_ch.right_button = res_q.rec.right_button;
	assign rec_ch.key_mask     = res_q.rec.key_mask;
	assign rec_ch.extra_bits   = res_q.rec.extra_bits;

	// A stalled final byte stays in s1 until its result can be written.
	`VTVD_ASSERT_NEXT(a_stalled_last_kept, valid_s1 && last_s1 && !out_free, valid_s1 && last_s1, "final byte lost while output stalled")
	// A result written is presented in the next cycle.
	`VTVD_ASSERT_NEXT(a_result_shown, res_wr, rec_ch.valid, "written result not presented")
	// A taken result is not presented again unless a new one was written.
	`VTVD_ASSERT_NEXT(a_result_not_repeated, rec_ch.valid && rec_ch.ready && !res_wr, !rec_ch.valid, "result repeated after transfer")
	// Only a final byte may write the result register.
	`VTVD_ASSERT_NOW(a_write_on_last, res_wr, valid_s1 && last_s1 && out_free, "result written without a final byte")

endmodule

`default_nettype wire

[test/varint_tag_value_message_decoder_test.sv]
`timescale 1ns / 1ps

module varint_tag_value_message_decoder_test import vtvd_pkg::*; ();

	logic clk;
	logic arst_n;

	vtvd_byte_if byte_ch();
	vtvd_rec_if  rec_ch();

	varint_tag_value_message_decoder DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.rec_ch  (rec_ch)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Chance in percent that the sender idles or the receiver stalls in a cycle.
	int gap_pct;
	int stall_pct;
	int fail_count;

	// Decoder shadow: varint assembly, per-message record, last good record.
	logic [63:0] vint_acc;
	logic [3:0]  vint_bytes;
	logic        want_value;
	logic [2:0]  pend_field;
	logic        msg_has_field;
	logic        msg_failed;
	vtvd_rec_t   msg_rec;
	vtvd_rec_t   held_rec;

	// Reports owed for final bytes already transferred, oldest first.
	vtvd_result_t reports_due[$];
	vtvd_result_t next_report;

	// Bytes of the message being built for sending.
	logic [7:0] msg_bytes[$];

	function automatic logic [15:0] clamp_s16(input logic [63:0] v);
		logic [31:0] w;
		w = v[31:0];
		if (!w[31])
			return (w > 32'h0000_7FFF) ? 16'h7FFF : w[15:0];
		if (w < 32'hFFFF_8000)
			return 16'h8000;
		return w[15:0];
	endfunction

	function automatic void start_message();
		vint_acc      = '0;
		vint_bytes    = '0;
		want_value    = 1'b0;
		pend_field    = '0;
		msg_rec       = '0;
		msg_has_field = 1'b0;
		msg_failed    = 1'b0;
	endfunction

	function automatic void apply_field(input logic [63:0] v);
		case (pend_field)
			FieldMouseX: msg_rec.mouse_x = clamp_s16(v);
			FieldMouseY: msg_rec.mouse_y = clamp_s16(v);
			FieldMouseZ: msg_rec.mouse_z = clamp_s16(v);
			FieldLeft:   msg_rec.left_button = (v != 64'd0);
			FieldRight:  msg_rec.right_button = (v != 64'd0);
			FieldKeys: begin
				msg_rec.key_mask   = v[15:0];
				msg_rec.extra_bits = v[31:16];
			end
			FieldExtra:  msg_rec.extra_bits[0] = (v != 64'd0);
			default: begin
				msg_failed = 1'b1;
				return;
			end
		endcase
		msg_has_field = 1'b1;
	endfunction

	// Advance the shadow by one transferred byte; queue a report on a final byte.
	function automatic void decode_byte(input logic [7:0] b, input logic is_last);
		logic [63:0]  v;
		logic [31:0]  fnum;
		vtvd_result_t r;
		if (!msg_failed) begin
			vint_acc = vint_acc | ({57'd0, b[6:0]} << (7 * vint_bytes));
			if (b[7]) begin
				vint_bytes = vint_bytes + 4'd1;
				if (vint_bytes >= VarintMaxBytes)
					msg_failed = 1'b1;
			end else begin
				v          = vint_acc;
				vint_acc   = '0;
				vint_bytes = '0;
				if (!want_value) begin
					// Tag bits above 34 are ignored.
					fnum = v[34:3];
					if (v[2:0] != 3'd0 || fnum == 32'd0 || fnum > 32'd7) begin
						msg_failed = 1'b1;
					end else begin
						pend_field = fnum[2:0];
						want_value = 1'b1;
					end
				end else begin
					apply_field(v);
					want_value = 1'b0;
				end
			end
		end
		if (is_last) begin
			// A varint cut short or a tag with no value fails the message.
			if (!msg_failed && (vint_bytes != 4'd0 || want_value))
				msg_failed = 1'b1;
			r.decode_ok = !msg_failed && msg_has_field;
			if (r.decode_ok)
				held_rec = msg_rec;
			r.rec = held_rec;
			reports_due.push_back(r);
			start_message();
		end
	endfunction

	// Append a varint; pad adds redundant zero groups, 11 bytes or more overflows.
	function automatic void add_varint(input logic [63:0] v, input int pad);
		int         n;
		int         total;
		logic [7:0] b;
		n = 1;
		while (n < 10 && (v >> (7 * n)) != 64'd0)
			n++;
		total = n + pad;
		if (total > 10)
			total = (pad >= 11) ? 11 : 10;
		for (int i = 0; i < total; i++) begin
			b[6:0] = 7'(v >> (7 * i));
			b[7]   = (i < total - 1);
			// The tenth byte only feeds bit 63; fill its other bits with junk.
			if (i == 9 && $urandom_range(1) == 1)
				b[6:1] = 6'($urandom);
			msg_bytes.push_back(b);
		end
	endfunction

	function automatic void add_raw(input logic [7:0] b, input int count);
		repeat (count) msg_bytes.push_back(b);
	endfunction

	function automatic logic [63:0] good_tag();
		logic [28:0] hi;
		hi = ($urandom_range(7) == 0) ? 29'($urandom) : 29'd0;
		return {hi, 32'($urandom_range(1, 7)), 3'b000};
	endfunction

	function automatic logic [63:0] bad_field_tag();
		logic [31:0] fnum;
		case ($urandom_range(2))
			0:       fnum = 32'd0;
			1:       fnum = 32'($urandom_range(8, 300));
			default: fnum = $urandom | 32'h8;
		endcase
		return {29'($urandom), fnum, 3'b000};
	endfunction

	function automatic logic [63:0] rand_value();
		case ($urandom_range(6))
			0: return 64'($urandom_range(0, 3));
			1: return 64'($urandom_range(0, 300));
			2: return {32'd0, $urandom};
			3: return {$urandom, $urandom};
			4: return -64'($urandom_range(1, 40000));
			5: return 64'($urandom_range(32'h7FF0, 32'h8010));
			default: begin
				case ($urandom_range(5))
					0: return 64'h0000_0000_7FFF_FFFF;
					1: return 64'h0000_0000_8000_0000;
					2: return 64'h0000_0000_FFFF_8000;
					3: return 64'h0000_0000_FFFF_7FFF;
					4: return 64'h8000_0000_0000_0000;
					default: return 64'hFFFF_FFFF_FFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic int pick_pad();
		return ($urandom_range(7) == 0) ? $urandom_range(1, 9) : 0;
	endfunction

	// Mostly well-formed messages with random content; the rest noise or broken.
	function automatic void build_random_message();
		msg_bytes.delete();
		if ($urandom_range(99) < 80) begin
			repeat ($urandom_range(1, 4)) begin
				add_varint(good_tag(), pick_pad());
				add_varint(rand_value(), pick_pad());
			end
		end else begin
			if ($urandom_range(1) == 1) begin
				add_varint(good_tag(), pick_pad());
				add_varint(rand_value(), pick_pad());
			end
			case ($urandom_range(5))
				0: repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom));
				1: begin
					// Wire type other than zero.
					add_varint(good_tag() | 64'($urandom_range(1, 7)), 0);
					add_varint(rand_value(), 0);
				end
				2: begin
					add_varint(bad_field_tag(), pick_pad());
					add_varint(rand_value(), 0);
				end
				3: add_varint(good_tag(), pick_pad());
				4: begin
					// Cut the value short: the final byte still asks for more.
					add_varint(good_tag(), 0);
					add_varint(rand_value(), pick_pad());
					msg_bytes[msg_bytes.size() - 1][7] = 1'b1;
				end
				default: begin
					add_varint(good_tag(), 0);
					add_varint(rand_value(), 11);
				end
			endcase
			// Trailing bytes after an error must be dropped.
			repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom));
		end
	endfunction

	// Send one byte: idle at random first, then hold valid until the transfer.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(99) < gap_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.byte_in   <= b;
		byte_ch.last_byte <= is_last;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		decode_byte(b, is_last);
	endtask

	task automatic send_message();
		foreach (msg_bytes[i])
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
	endtask

	// Receiver: stall at random, at the rate the current phase sets.
	always @(posedge clk)
		rec_ch.ready <= ($urandom_range(99) >= stall_pct);

	function automatic void compare_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// Check each report transfer against the oldest owed report.
	always @(posedge clk) begin
		if (arst_n && rec_ch.valid && rec_ch.ready) begin
			if (reports_due.size() == 0) begin
				$error("report transfer with no final byte pending");
				fail_count++;
			end else begin
				next_report = reports_due.pop_front();
				compare_field("decode_ok", 16'(next_report.decode_ok), 16'(rec_ch.decode_ok));
				compare_field("mouse_x", next_report.rec.mouse_x, rec_ch.mouse_x);
				compare_field("mouse_y", next_report.rec.mouse_y, rec_ch.mouse_y);
				compare_field("mouse_z", next_report.rec.mouse_z, rec_ch.mouse_z);
				compare_field("left_button", 16'(next_report.rec.left_button),
					16'(rec_ch.left_button));
				compare_field("right_button", 16'(next_report.rec.right_button),
					16'(rec_ch.right_button));
				compare_field("key_mask", next_report.rec.key_mask, rec_ch.key_mask);
				compare_field("extra_bits", next_report.rec.extra_bits, rec_ch.extra_bits);
			end
		end
	end

	// Saturation at both ends, exact minimum, key mask and reserved bit, buttons.
	task automatic test_field_extremes();
		msg_bytes.delete();
		add_varint({29'd0, 32'(FieldMouseX), 3'b000}, 0);
		add_varint(64'h0000_0000_7FFF_FFFF, 0);
		add_varint({29'd0, 32'(FieldMouseY), 3'b000}, 0);
		add_varint(64'h0000_0000_8000_0000, 0);
		add_varint({29'd0, 32'(FieldMouseZ), 3'b000}, 0);
		add_varint(64'h0000_0000_FFFF_8000, 0);
		send_message();
		msg_bytes.delete();
		add_varint({29'd0, 32'(FieldKeys), 3'b000}, 0);
		add_varint(64'h0000_0000_FFFF_FFFF, 0);
		add_varint({29'd0, 32'(FieldExtra), 3'b000}, 0);
		add_varint(64'd0, 0);
		send_message();
		msg_bytes.delete();
		add_varint({29'd0, 32'(FieldExtra), 3'b000}, 0);
		add_raw(8'hFF, 1);
		add_raw(8'h7F, 1);
		add_varint({29'd0, 32'(FieldLeft), 3'b000}, 0);
		add_varint(64'd1, 0);
		add_varint({29'd0, 32'(FieldRight), 3'b000}, 0);
		add_varint(64'd2, 0);
		send_message();
	endtask

	// Ten-byte varints: the tenth byte feeds only bit 63.
	task automatic test_long_varints();
		msg_bytes.delete();
		add_varint({29'd0, 32'(FieldLeft), 3'b000}, 0);
		add_raw(8'h80, 9);
		add_raw(8'h7E, 1);
		add_varint({29'd0, 32'(FieldRight), 3'b000}, 0);
		add_raw(8'h80, 9);
		add_raw(8'h01, 1);
		send_message();
	endtask

	// Bad tags, ignored high tag bits, overflow and truncation.
	task automatic test_bad_messages();
		msg_bytes.delete();
		add_raw(8'h09, 1);
		add_raw(8'h00, 1);
		send_message();
		msg_bytes.delete();
		add_raw(8'h00, 1);
		send_message();
		msg_bytes.delete();
		add_raw(8'h40, 1);
		add_raw(8'h01, 1);
		send_message();
		msg_bytes.delete();
		add_varint({29'h1555_5555, 32'(FieldMouseX), 3'b000}, 0);
		add_raw(8'h05, 1);
		send_message();
		msg_bytes.delete();
		add_varint({29'd0, 32'h8000_0001, 3'b000}, 0);
		add_raw(8'h05, 1);
		send_message();
		msg_bytes.delete();
		add_raw(8'h08, 1);
		add_raw(8'h80, 10);
		add_raw(8'h00, 1);
		send_message();
		msg_bytes.delete();
		add_raw(8'h08, 1);
		add_raw(8'h85, 1);
		send_message();
		msg_bytes.delete();
		add_raw(8'h10, 1);
		send_message();
	endtask

	task automatic test_random_messages(input int gap, input int stall, input int n_bytes);
		int sent;
		gap_pct   = gap;
		stall_pct = stall;
		sent      = 0;
		while (sent < n_bytes) begin
			build_random_message();
			send_message();
			sent += msg_bytes.size();
		end
	endtask

	// Hold the sender off until every owed report has been taken, then resume.
	task automatic test_pause_until_drained();
		gap_pct   = 0;
		stall_pct = 68;
		build_random_message();
		send_message();
		byte_ch.valid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		build_random_message();
		send_message();
	endtask

	initial begin
		fail_count        = 0;
		gap_pct           = 0;
		stall_pct         = 0;
		byte_ch.valid     = 1'b0;
		byte_ch.byte_in   = 8'd0;
		byte_ch.last_byte = 1'b0;
		start_message();
		held_rec = '0;
		arst_n   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_long_varints();
		test_bad_messages();
		test_random_messages(0, 0, 280);
		test_random_messages(68, 0, 280);
		test_random_messages(0, 68, 280);
		test_random_messages(33, 33, 280);
		test_pause_until_drained();

		byte_ch.valid <= 1'b0;
		stall_pct = 0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
